[hw/rtl/mamdani_fuzzy_congestion_estimator_assert.svh]
// ----------------------------------------------------------------------------
// mamdani_fuzzy_congestion_estimator_assert: assertion macros
// Each macro expands to one labeled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef MAMDANI_FUZZY_CONGESTION_ESTIMATOR_ASSERT_SVH
`define MAMDANI_FUZZY_CONGESTION_ESTIMATOR_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define MFCE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfce assertion failed");

// The consequent holds in the cycle after the antecedent.
`define MFCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfce assertion failed");

`endif

[hw/rtl/mfce_pkg.sv]
// ----------------------------------------------------------------------------
// mfce_pkg: shared types and constants of the fuzzy congestion estimator
// Payload structs, membership breakpoints, reciprocals and output set tables.
// ----------------------------------------------------------------------------
package mfce_pkg;

  localparam int DEGREE_FRAC_BITS = 12;
  localparam int CENTROID_STEP    = 5;
  localparam int AXIS_MAX         = 100;
  localparam int NPTS             = AXIS_MAX / CENTROID_STEP + 1;
  localparam int DEG_W            = DEGREE_FRAC_BITS + 1;
  localparam int SLOPE_W          = 12;
  localparam int RCP_SHIFT        = 36;
  localparam int RCP_W            = 27;
  localparam int PROD_W           = 19;
  localparam int NUM_W            = 23;
  localparam int DEN_W            = 17;
  localparam int LEVEL_W          = 15;
  localparam int NSETS            = 6;
  localparam int GROUP            = 7;
  localparam int NGRP             = (NPTS + GROUP - 1) / GROUP;

  localparam logic [DEG_W-1:0] DEG_ONE = DEG_W'(1) << DEGREE_FRAC_BITS;

  // Configuration register indexes
  localparam logic [2:0] CFG_TRAVEL_LIMIT    = 3'd0;
  localparam logic [2:0] CFG_OCCUPANCY_LIMIT = 3'd1;
  localparam logic [2:0] CFG_SMOOTH_THRESH   = 3'd2;
  localparam logic [2:0] CFG_DENSE_THRESH    = 3'd3;

  // Status codes
  localparam logic [1:0] STATUS_SMOOTH = 2'd0;
  localparam logic [1:0] STATUS_DENSE  = 2'd1;
  localparam logic [1:0] STATUS_JAMMED = 2'd2;

  // Membership regions
  localparam logic [1:0] REGION_ZERO = 2'd0;
  localparam logic [1:0] REGION_ONE  = 2'd1;
  localparam logic [1:0] REGION_RISE = 2'd2;
  localparam logic [1:0] REGION_FALL = 2'd3;

  typedef struct packed {
    logic [15:0] travel_ms;
    logic [15:0] occupancy_ms;
  } in_req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] congestion_level;
    logic [1:0]         status_code;
    logic               no_rule_fired;
  } out_res_t;

  typedef struct packed {
    logic [1:0]         region;
    logic [SLOPE_W-1:0] y;
  } mem_prep_t;

  // Sets 0..2: fast, medium, slow travel. Sets 3..5: short, medium, long occupancy.
  localparam logic [15:0] SET_A [NSETS] = '{16'd0, 16'd2000, 16'd5000,
                                            16'd0, 16'd1000, 16'd2500};
  localparam logic [15:0] SET_B [NSETS] = '{16'd0, 16'd4000, 16'd8000,
                                            16'd0, 16'd2000, 16'd4000};
  localparam logic [15:0] SET_C [NSETS] = '{16'd1500, 16'd4000, 16'd10000,
                                            16'd500, 16'd2000, 16'd5000};
  localparam logic [15:0] SET_D [NSETS] = '{16'd3000, 16'd6000, 16'd10000,
                                            16'd1500, 16'd3000, 16'd5000};
  // Each set has one slope width, used by each of its sloped edges
  localparam logic [SLOPE_W-1:0] SET_DIV [NSETS] = '{12'd1500, 12'd2000, 12'd3000,
                                                     12'd1000, 12'd1000, 12'd1500};

  localparam logic [RCP_W-1:0] RCP_1000 = RCP_W'((64'd1 << RCP_SHIFT) / 64'd1000);
  localparam logic [RCP_W-1:0] RCP_1500 = RCP_W'((64'd1 << RCP_SHIFT) / 64'd1500);
  localparam logic [RCP_W-1:0] RCP_2000 = RCP_W'((64'd1 << RCP_SHIFT) / 64'd2000);
  localparam logic [RCP_W-1:0] RCP_3000 = RCP_W'((64'd1 << RCP_SHIFT) / 64'd3000);
  localparam logic [RCP_W-1:0] SET_RCP [NSETS] = '{RCP_1500, RCP_2000, RCP_3000,
                                                   RCP_1000, RCP_1000, RCP_1500};

  // Output set degrees at z = 0, 5, ..., 100
  localparam logic [DEG_W-1:0] OUT_SMOOTH [NPTS] = '{
    13'd4096, 13'd4096, 13'd4096, 13'd3413, 13'd2730, 13'd2048, 13'd1365,
    13'd682,  13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,
    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0};
  localparam logic [DEG_W-1:0] OUT_DENSE [NPTS] = '{
    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd682,  13'd1365,
    13'd2048, 13'd2730, 13'd3413, 13'd4096, 13'd3413, 13'd2730, 13'd2048,
    13'd1365, 13'd682,  13'd0,    13'd0,    13'd0,    13'd0,    13'd0};
  localparam logic [DEG_W-1:0] OUT_JAMMED [NPTS] = '{
    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,
    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd1024,
    13'd2048, 13'd3072, 13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd4096};

  function automatic logic [DEG_W-1:0] dmin(input logic [DEG_W-1:0] p,
                                            input logic [DEG_W-1:0] q);
    return (p < q) ? p : q;
  endfunction

  function automatic logic [DEG_W-1:0] dmax(input logic [DEG_W-1:0] p,
                                            input logic [DEG_W-1:0] q);
    return (p > q) ? p : q;
  endfunction

  // Classify x against a trapezoid; shoulders win over the outer zero test
  function automatic mem_prep_t member_prep(input logic [15:0] x, input logic [15:0] a,
                                            input logic [15:0] b, input logic [15:0] c,
                                            input logic [15:0] d);
    mem_prep_t r;
    r.y = '0;
    if (a == b && x <= b) begin
      r.region = REGION_ONE;
    end else if (c == d && x >= c) begin
      r.region = REGION_ONE;
    end else if (x <= a || x >= d) begin
      r.region = REGION_ZERO;
    end else if (x >= b && x <= c) begin
      r.region = REGION_ONE;
    end else if (x < b) begin
      r.region = REGION_RISE;
      r.y      = SLOPE_W'(x - a);
    end else begin
      r.region = REGION_FALL;
      r.y      = SLOPE_W'(d - x);
    end
    return r;
  endfunction

endpackage

[hw/rtl/mamdani_fuzzy_congestion_estimator.sv]
// ----------------------------------------------------------------------------
// mamdani_fuzzy_congestion_estimator: two-input nine-rule fuzzy estimator
// Clamps, fuzzifies, applies min/max rules and takes a 21-point centroid.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in_     | request   | in_valid/in_stall  | in_req_t: travel_ms, occupancy_ms
//  out_    | result    | out_valid/out_stall| out_res_t: level, status, flag
//  cfg_    | write     | cfg_we             | cfg_index, cfg_wdata
//
// One request per clock unless in_stall is high; the pipeline holds the
// 15 one-bit stages of the centroid divider plus ten fuzzification,
// summing and output stages.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
// A stage holds while the stage after it is full and held; bubbles close up,
// so out_stall stalls in_ only once every stage is full.

`include "mamdani_fuzzy_congestion_estimator_assert.svh"

module mamdani_fuzzy_congestion_estimator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mfce_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mfce_pkg::out_res_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);
  import mfce_pkg::*;

  localparam int DIV_BITS = LEVEL_W;
  localparam int ST_DIV0  = 9;
  localparam int ST_OUT   = ST_DIV0 + DIV_BITS;
  localparam int NST      = ST_OUT + 1;
  localparam int DREM_W   = NUM_W + 8;

  // Configuration registers
  logic [15:0]        travel_limit_r, occupancy_limit_r;
  logic [LEVEL_W-1:0] smooth_thresh_r, dense_thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      travel_limit_r    <= 16'd10000;
      occupancy_limit_r <= 16'd5000;
      smooth_thresh_r   <= LEVEL_W'(8960);
      dense_thresh_r    <= LEVEL_W'(16640);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRAVEL_LIMIT:    travel_limit_r    <= cfg_wdata;
        CFG_OCCUPANCY_LIMIT: occupancy_limit_r <= cfg_wdata;
        CFG_SMOOTH_THRESH:   smooth_thresh_r   <= cfg_wdata[LEVEL_W-1:0];
        CFG_DENSE_THRESH:    dense_thresh_r    <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valids and per-stage load enables; a stage loads when empty or draining
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Stage 0: clamp to the limit registers
  logic [15:0] tt_r, ot_r;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      tt_r <= (in_data.travel_ms < travel_limit_r) ? in_data.travel_ms : travel_limit_r;
      ot_r <= (in_data.occupancy_ms < occupancy_limit_r) ? in_data.occupancy_ms
                                                         : occupancy_limit_r;
    end
  end

  // Stage 1: region of each set and slope offset
  mem_prep_t prep_r [NSETS];
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int s = 0; s < NSETS; s++) begin
        prep_r[s] <= member_prep((s < 3) ? tt_r : ot_r,
                                 SET_A[s], SET_B[s], SET_C[s], SET_D[s]);
      end
    end
  end

  // Stage 2: quotient estimate by reciprocal, may be one low
  mem_prep_t          prep2_r [NSETS];
  logic [SLOPE_W-1:0] q0_r    [NSETS];
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int s = 0; s < NSETS; s++) begin
        prep2_r[s] <= prep_r[s];
        q0_r[s]    <= SLOPE_W'(((SLOPE_W + RCP_W)'(prep_r[s].y) * SET_RCP[s])
                               >> (RCP_SHIFT - DEGREE_FRAC_BITS));
      end
    end
  end

  // Stage 3: correct the estimate and form the degree
  logic [DEG_W-1:0] deg_r [NSETS];
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int s = 0; s < NSETS; s++) begin
        case (prep2_r[s].region)
          REGION_ZERO: deg_r[s] <= '0;
          REGION_ONE:  deg_r[s] <= DEG_ONE;
          default: begin
            if (({prep2_r[s].y, DEGREE_FRAC_BITS'(0)}
                 - (SLOPE_W + DEGREE_FRAC_BITS)'(q0_r[s])
                   * (SLOPE_W + DEGREE_FRAC_BITS)'(SET_DIV[s]))
                >= (SLOPE_W + DEGREE_FRAC_BITS)'(SET_DIV[s])) begin
              deg_r[s] <= DEG_W'(q0_r[s]) + DEG_W'(1);
            end else begin
              deg_r[s] <= DEG_W'(q0_r[s]);
            end
          end
        endcase
      end
    end
  end

  // Stage 4: rule strengths
  logic [DEG_W-1:0] s_smooth_r, s_dense_r, s_jam_r;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s_smooth_r <= dmax(dmin(deg_r[0], deg_r[3]),
                    dmax(dmin(deg_r[0], deg_r[4]), dmin(deg_r[1], deg_r[3])));
      s_dense_r  <= dmax(dmin(deg_r[0], deg_r[5]),
                    dmax(dmin(deg_r[1], deg_r[4]), dmin(deg_r[2], deg_r[3])));
      s_jam_r    <= dmax(dmin(deg_r[1], deg_r[5]),
                    dmax(dmin(deg_r[2], deg_r[4]), dmin(deg_r[2], deg_r[5])));
    end
  end

  // Stage 5: clipped and combined degree at each sample point
  logic [DEG_W-1:0] mu_r [NPTS];
  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int k = 0; k < NPTS; k++) begin
        mu_r[k] <= dmax(dmin(OUT_SMOOTH[k], s_smooth_r),
                   dmax(dmin(OUT_DENSE[k], s_dense_r), dmin(OUT_JAMMED[k], s_jam_r)));
      end
    end
  end

  // Stage 6: weight each point by its position
  logic [PROD_W-1:0] prod_r [NPTS];
  logic [DEG_W-1:0]  mu6_r  [NPTS];
  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int k = 0; k < NPTS; k++) begin
        prod_r[k] <= PROD_W'(mu_r[k]) * PROD_W'(k * CENTROID_STEP);
        mu6_r[k]  <= mu_r[k];
      end
    end
  end

  // Stage 7: group sums
  logic [NUM_W-1:0] gnum_r [NGRP];
  logic [DEN_W-1:0] gden_r [NGRP];
  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int g = 0; g < NGRP; g++) begin
        logic [NUM_W-1:0] n_acc;
        logic [DEN_W-1:0] d_acc;
        n_acc = '0;
        d_acc = '0;
        for (int i = 0; i < GROUP; i++) begin
          if (g * GROUP + i < NPTS) begin
            n_acc = n_acc + NUM_W'(prod_r[g*GROUP+i]);
            d_acc = d_acc + DEN_W'(mu6_r[g*GROUP+i]);
          end
        end
        gnum_r[g] <= n_acc;
        gden_r[g] <= d_acc;
      end
    end
  end

  // Stage 8: totals
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  always_ff @(posedge clk) begin
    if (en[8]) begin
      logic [NUM_W-1:0] n_acc;
      logic [DEN_W-1:0] d_acc;
      n_acc = '0;
      d_acc = '0;
      for (int g = 0; g < NGRP; g++) begin
        n_acc = n_acc + gnum_r[g];
        d_acc = d_acc + gden_r[g];
      end
      num_r <= n_acc;
      den_r <= d_acc;
    end
  end

  // Stages 9..23: restoring divider, one quotient bit per stage, MSB first
  logic [DREM_W-1:0]  dv_rem_r [DIV_BITS];
  logic [DEN_W-1:0]   dv_den_r [DIV_BITS];
  logic [LEVEL_W-1:0] dv_quo_r [DIV_BITS];
  logic [DREM_W-1:0]  dv_src_rem [DIV_BITS];
  logic [DEN_W-1:0]   dv_src_den [DIV_BITS];
  logic [LEVEL_W-1:0] dv_src_quo [DIV_BITS];
  logic [DREM_W:0]    dv_diff    [DIV_BITS];

  always_comb begin
    for (int j = 0; j < DIV_BITS; j++) begin
      if (j == 0) begin
        dv_src_rem[j] = {num_r, 8'd0};
        dv_src_den[j] = den_r;
        dv_src_quo[j] = '0;
      end else begin
        dv_src_rem[j] = dv_rem_r[j-1];
        dv_src_den[j] = dv_den_r[j-1];
        dv_src_quo[j] = dv_quo_r[j-1];
      end
      dv_diff[j] = {1'b0, dv_src_rem[j]}
                 - ((DREM_W + 1)'(dv_src_den[j]) << (DIV_BITS - 1 - j));
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_BITS; j++) begin
      if (en[ST_DIV0+j]) begin
        dv_den_r[j] <= dv_src_den[j];
        dv_rem_r[j] <= dv_diff[j][DREM_W] ? dv_src_rem[j] : dv_diff[j][DREM_W-1:0];
        dv_quo_r[j] <= {dv_src_quo[j][LEVEL_W-2:0], !dv_diff[j][DREM_W]};
      end
    end
  end

  // Stage 24: force zero when nothing fired, classify, hold for the consumer
  out_res_t           out_r;
  logic               none_w;
  logic [LEVEL_W-1:0] level_w;

  assign none_w  = (dv_den_r[DIV_BITS-1] == '0);
  assign level_w = none_w ? '0 : dv_quo_r[DIV_BITS-1];

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_r.congestion_level <= level_w;
      out_r.no_rule_fired    <= none_w;
      if (level_w <= smooth_thresh_r) begin
        out_r.status_code <= STATUS_SMOOTH;
      end else if (level_w <= dense_thresh_r) begin
        out_r.status_code <= STATUS_DENSE;
      end else begin
        out_r.status_code <= STATUS_JAMMED;
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_data  = out_r;

  `MFCE_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_valid && !in_stall, v_r[0])
  `MFCE_ASSERT_SAME(a_none_zero, clk, rst_n, out_valid && out_data.no_rule_fired,
                    out_data.congestion_level == '0)
  `MFCE_ASSERT_SAME(a_level_range, clk, rst_n, out_valid,
                    out_data.congestion_level <= LEVEL_W'(25600))
  `MFCE_ASSERT_SAME(a_smooth_status, clk, rst_n,
                    out_valid && out_data.status_code == STATUS_SMOOTH,
                    out_data.congestion_level <= smooth_thresh_r)

endmodule
